### rtl/core/plpm_pkg.sv
// Shared types, constants and helpers for the piecewise-linear pixel map.
package plpm_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_POINTS = 4;
  localparam int PT_IDX_W   = $clog2(MAX_POINTS);
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_ADDR_W = CFG_IDX_W + 2;
  localparam int PROD_W     = 2 * PIX_W;

  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = PIX_W / DIV_STEPS_PER_STAGE;

  typedef logic [MAX_POINTS-1:0][PIX_W-1:0] pt_vec_t;

  localparam pt_vec_t IN_PT_RESET  = {8'd255, 8'd192, 8'd128, 8'd0};
  localparam pt_vec_t OUT_PT_RESET = {8'd255, 8'd192, 8'd128, 8'd0};

  localparam logic [CFG_IDX_W-1:0] REG_IN_POINT_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_POINT_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_POINT_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IN_POINT_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINT_0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINT_1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINT_2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_POINT_3 = 3'd7;

  // selected segment: base output, offset into segment, run and rise
  typedef struct packed {
    logic [PIX_W-1:0]        base;
    logic [PIX_W-1:0]        offs;
    logic [PIX_W-1:0]        run;
    logic signed [PIX_W:0]   rise;
  } plpm_sel_t;

  // divider word: remainder in the upper half, dividend/quotient in the lower
  typedef struct packed {
    logic [PROD_W-1:0] word;
    logic [PIX_W-1:0]  run;
    logic              neg;
    logic [PIX_W-1:0]  base;
  } plpm_div_t;

  // one restoring division step; remainder always stays below run
  function automatic logic [PROD_W-1:0] div_step(input logic [PROD_W-1:0] w,
                                                 input logic [PIX_W-1:0]  run);
    logic [PIX_W:0] t;
    logic [PIX_W:0] d;
    t = {w[PROD_W-1:PIX_W], w[PIX_W-1]};
    d = t - {1'b0, run};
    if (t >= {1'b0, run}) begin
      div_step = {d[PIX_W-1:0], w[PIX_W-2:0], 1'b1};
    end else begin
      div_step = {t[PIX_W-1:0], w[PIX_W-2:0], 1'b0};
    end
  endfunction

endpackage

### rtl/core/plpm_cfg.sv
// APB register file holding the breakpoint inputs and outputs.
module plpm_cfg
  import plpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output pt_vec_t               in_pt,
  output pt_vec_t               out_pt
);

  logic [CFG_IDX_W-1:0] idx;
  logic [PIX_W-1:0]     rd_val;
  logic [PIX_W-1:0]     wr_val;
  logic                 wr_en;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_val = pwdata[PIX_W-1:0];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_pt  <= IN_PT_RESET;
      out_pt <= OUT_PT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_IN_POINT_0:  in_pt[0]  <= wr_val;
        REG_IN_POINT_1:  in_pt[1]  <= wr_val;
        REG_IN_POINT_2:  in_pt[2]  <= wr_val;
        REG_IN_POINT_3:  in_pt[3]  <= wr_val;
        REG_OUT_POINT_0: out_pt[0] <= wr_val;
        REG_OUT_POINT_1: out_pt[1] <= wr_val;
        REG_OUT_POINT_2: out_pt[2] <= wr_val;
        REG_OUT_POINT_3: out_pt[3] <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IN_POINT_0:  rd_val = in_pt[0];
      REG_IN_POINT_1:  rd_val = in_pt[1];
      REG_IN_POINT_2:  rd_val = in_pt[2];
      REG_IN_POINT_3:  rd_val = in_pt[3];
      REG_OUT_POINT_0: rd_val = out_pt[0];
      REG_OUT_POINT_1: rd_val = out_pt[1];
      REG_OUT_POINT_2: rd_val = out_pt[2];
      REG_OUT_POINT_3: rd_val = out_pt[3];
      default:         rd_val = '0;
    endcase
  end

  assign prdata = {{(CFG_DATA_W-PIX_W){1'b0}}, rd_val};

endmodule

### rtl/core/plpm_front.sv
// Segment select stage and product stage.
module plpm_front
  import plpm_pkg::*;
#(
  parameter int NUM_POINTS = 4
)(
  input  logic             clk,
  input  logic             rst,
  input  pt_vec_t          in_pt,
  input  pt_vec_t          out_pt,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] pixel_in,
  output logic             out_valid,
  input  logic             out_ready,
  output plpm_div_t        out_data
);

  logic      va;
  logic      vb;
  logic      rdy_a;
  logic      rdy_b;
  plpm_sel_t sa;
  plpm_sel_t sel_next;
  plpm_div_t sb_next;
  logic [PIX_W-1:0] x0;
  logic [PIX_W-1:0] x1;
  logic [PIX_W-1:0] abs_rise;
  logic [PIX_W:0]   neg_rise;

  assign rdy_b    = ~vb | out_ready;
  assign rdy_a    = ~va | rdy_b;
  assign in_ready = rdy_a;

  // walk segments from last to first so the first hit wins
  always_comb begin
    sel_next.base = pixel_in;
    sel_next.offs = '0;
    sel_next.run  = PIX_W'(1);
    sel_next.rise = '0;
    x0 = '0;
    x1 = '0;
    for (int k = NUM_POINTS - 1; k >= 1; k--) begin
      x0 = in_pt[PT_IDX_W'(k - 1)];
      x1 = in_pt[PT_IDX_W'(k)];
      if (pixel_in >= x0 && pixel_in <= x1) begin
        sel_next.base = out_pt[PT_IDX_W'(k - 1)];
        if (x1 == x0) begin
          sel_next.offs = '0;
          sel_next.run  = PIX_W'(1);
          sel_next.rise = '0;
        end else begin
          sel_next.offs = pixel_in - x0;
          sel_next.run  = x1 - x0;
          sel_next.rise = $signed({1'b0, out_pt[PT_IDX_W'(k)]})
                        - $signed({1'b0, out_pt[PT_IDX_W'(k - 1)]});
        end
      end
    end
  end

  always_comb begin
    neg_rise      = -sa.rise;
    abs_rise      = sa.rise[PIX_W] ? neg_rise[PIX_W-1:0] : sa.rise[PIX_W-1:0];
    sb_next.word  = {{PIX_W{1'b0}}, sa.offs} * {{PIX_W{1'b0}}, abs_rise};
    sb_next.run   = sa.run;
    sb_next.neg   = sa.rise[PIX_W];
    sb_next.base  = sa.base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdy_a) begin
        va <= in_valid;
      end
      if (rdy_b) begin
        vb <= va;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      sa <= sel_next;
    end
    if (rdy_b && va) begin
      out_data <= sb_next;
    end
  end

  assign out_valid = vb;

endmodule

### rtl/core/plpm_div.sv
// Pipelined restoring divider, a few quotient bits per stage.
module plpm_div
  import plpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  plpm_div_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output plpm_div_t out_data
);

  logic      sv  [DIV_STAGES];
  plpm_div_t sd  [DIV_STAGES];
  logic      rdy [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic      pv;
    plpm_div_t pd;
    plpm_div_t nd;
    logic      nxt_rdy;

    if (i == 0) begin : g_first
      assign pv = in_valid;
      assign pd = in_data;
    end else begin : g_rest
      assign pv = sv[i-1];
      assign pd = sd[i-1];
    end

    if (i == DIV_STAGES - 1) begin : g_last
      assign nxt_rdy = out_ready;
    end else begin : g_mid
      assign nxt_rdy = rdy[i+1];
    end

    assign rdy[i] = ~sv[i] | nxt_rdy;

    always_comb begin
      nd = pd;
      for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
        nd.word = div_step(nd.word, pd.run);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (rdy[i]) begin
        sv[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && pv) begin
        sd[i] <= nd;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = sv[DIV_STAGES-1];
  assign out_data  = sd[DIV_STAGES-1];

endmodule

### rtl/core/plpm_out.sv
// Sign fix, offset add and output register.
module plpm_out
  import plpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  plpm_div_t        in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] pixel_out
);

  logic             rdy;
  logic [PIX_W-1:0] quo;
  logic [PIX_W-1:0] res;

  assign rdy      = ~out_valid | out_ready;
  assign in_ready = rdy;
  assign quo      = in_data.word[PIX_W-1:0];
  assign res      = in_data.neg ? (in_data.base - quo) : (in_data.base + quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      pixel_out <= res;
    end
  end

endmodule

### rtl/core/piecewise_linear_pixel_map.sv
// Top level of the piecewise-linear pixel map.
//
//   channel   direction  handshake                    payload
//   pixel in  in         in_valid / in_ready          pixel_in[7:0]
//   pixel out out        out_valid / out_ready        pixel_out[7:0]
//   config    in/out     psel, penable, pwrite, pready paddr[4:0], pwdata, prdata
//
// Seven register stages: segment select, product, four divider stages of two
// quotient bits each, output add. One transfer per cycle unless the output
// stalls. Each stage holds its item until the next stage is free; empty
// stages fill while the output waits. Synchronous reset clears all valid
// bits and sets the breakpoints to 0/128/192/255.
module piecewise_linear_pixel_map
  import plpm_pkg::*;
#(
  parameter int NUM_POINTS = 4
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      pixel_out
);

  pt_vec_t   in_pt;
  pt_vec_t   out_pt;
  logic      f_valid;
  logic      f_ready;
  plpm_div_t f_data;
  logic      d_valid;
  logic      d_ready;
  plpm_div_t d_data;

  assign pready = 1'b1;

  plpm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .in_pt   (in_pt),
    .out_pt  (out_pt)
  );

  plpm_front #(
    .NUM_POINTS (NUM_POINTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_pt     (in_pt),
    .out_pt    (out_pt),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  plpm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  plpm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_data   (d_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out)
  );

endmodule

### rtl/core/plpm_checker.sv
// Port-level checks for the piecewise-linear pixel map, bound to the top level.
module plpm_checker
  import plpm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             pready,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] pixel_out
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free output stage");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pixel_out)))
    else $error("output transfer dropped or changed while stalled");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind piecewise_linear_pixel_map plpm_checker u_plpm_checker (.*);

### dv/plpm_checker.sv
`timescale 1ns / 100ps
// Pixel map checker: tracks register writes, predicts each pixel and compares the outputs.
module plpm_tb_checker
  import plpm_pkg::*;
#(
  parameter int NUM_POINTS = 4
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PIX_W-1:0]      pixel_in,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PIX_W-1:0]      pixel_out,
  output int                    fail_count,
  output int                    pending
);

  pt_vec_t              in_pts;
  pt_vec_t              out_pts;
  logic [PIX_W-1:0]     pixel_out_expected[$];
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [PIX_W-1:0]     want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [PIX_W-1:0] stretch_pixel(input logic [PIX_W-1:0] pix,
                                                     input pt_vec_t xs, input pt_vec_t ys);
    int               k;
    int               x0;
    int               x1;
    int               y0;
    int               y1;
    int               mapped;
    logic             found;
    logic [PIX_W-1:0] res;
    res   = pix;
    found = 1'b0;
    for (k = 1; k < NUM_POINTS; k++) begin
      x0 = int'(xs[PT_IDX_W'(k-1)]);
      x1 = int'(xs[PT_IDX_W'(k)]);
      y0 = int'(ys[PT_IDX_W'(k-1)]);
      y1 = int'(ys[PT_IDX_W'(k)]);
      if (!found && int'(pix) >= x0 && int'(pix) <= x1) begin
        found = 1'b1;
        if (x1 == x0) begin
          mapped = y0;
        end else begin
          mapped = y0 + ((int'(pix) - x0) * (y1 - y0)) / (x1 - x0);
        end
        res = mapped[PIX_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] reg_value(input logic [CFG_IDX_W-1:0] idx);
    if (idx < REG_OUT_POINT_0) begin
      return in_pts[idx[PT_IDX_W-1:0]];
    end
    return out_pts[idx[PT_IDX_W-1:0]];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_pts  = IN_PT_RESET;
      out_pts = OUT_PT_RESET;
      pixel_out_expected.delete();
    end else begin
      if (psel && penable && pready) begin
        reg_idx = paddr[CFG_ADDR_W-1:2];
        if (pwrite) begin
          if (reg_idx < REG_OUT_POINT_0) begin
            in_pts[reg_idx[PT_IDX_W-1:0]] = pwdata[PIX_W-1:0];
          end else begin
            out_pts[reg_idx[PT_IDX_W-1:0]] = pwdata[PIX_W-1:0];
          end
        end else if (prdata[PIX_W-1:0] !== reg_value(reg_idx)) begin
          report_mismatch($sformatf("prdata reg %0d: got %0d, want %0d",
                                    reg_idx, prdata[PIX_W-1:0], reg_value(reg_idx)));
        end
      end
      if (out_valid && out_ready) begin
        if (pixel_out_expected.size() == 0) begin
          report_mismatch($sformatf("pixel_out %0d transfer with nothing pending", pixel_out));
        end else begin
          want = pixel_out_expected.pop_front();
          if (pixel_out !== want) begin
            report_mismatch($sformatf("pixel_out: got %0d, want %0d", pixel_out, want));
          end
        end
      end
      if (in_valid && in_ready) begin
        pixel_out_expected.push_back(stretch_pixel(pixel_in, in_pts, out_pts));
      end
    end
    pending <= pixel_out_expected.size();
  end

endmodule

### dv/tb_piecewise_linear_pixel_map.sv
`timescale 1ns / 100ps
// Testbench top for the pixel map: clock, reset, register and pixel stimulus, verdict.
module tb_piecewise_linear_pixel_map;
  import plpm_pkg::*;

  localparam int NUM_POINTS   = 4;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 12;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel_in  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      pixel_out;

  int      fail_count;
  int      pending;
  bit      hold_req   = 1'b0;
  bit      burst_mode = 1'b0;
  pt_vec_t cur_in;

  always #10 clk = ~clk;

  piecewise_linear_pixel_map #(.NUM_POINTS(NUM_POINTS)) u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .pixel_in, .out_valid, .out_ready, .pixel_out
  );

  plpm_tb_checker #(.NUM_POINTS(NUM_POINTS)) u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .prdata,
    .in_valid, .in_ready, .pixel_in, .out_valid, .out_ready, .pixel_out,
    .fail_count, .pending
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    logic [PIX_W-1:0] bp;
    if ($urandom_range(0, 9) < 3) begin
      bp = cur_in[PT_IDX_W'($urandom_range(0, MAX_POINTS-1))];
      return bp + PIX_W'($urandom_range(0, 2)) - PIX_W'(1);
    end
    return PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic is_write, input logic [CFG_IDX_W-1:0] idx,
                            input logic [PIX_W-1:0] value);
    logic [CFG_DATA_W-1:0] wdata;
    wdata             = $urandom();
    wdata[PIX_W-1:0]  = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic load_curve(input pt_vec_t xs, input pt_vec_t ys);
    int k;
    wait_idle();
    for (k = 0; k < MAX_POINTS; k++) begin
      cfg_access(1'b1, CFG_IDX_W'(REG_IN_POINT_0 + k), xs[PT_IDX_W'(k)]);
      cfg_access(1'b1, CFG_IDX_W'(REG_OUT_POINT_0 + k), ys[PT_IDX_W'(k)]);
    end
    for (k = 0; k < MAX_POINTS; k++) begin
      cfg_access(1'b0, CFG_IDX_W'(REG_IN_POINT_0 + k), '0);
      cfg_access(1'b0, CFG_IDX_W'(REG_OUT_POINT_0 + k), '0);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    cur_in  = xs;
  endtask

  task automatic random_curve(output pt_vec_t xs, output pt_vec_t ys);
    int               mode;
    int               i;
    int               j;
    logic [PIX_W-1:0] t;
    for (i = 0; i < MAX_POINTS; i++) begin
      xs[PT_IDX_W'(i)] = PIX_W'($urandom_range(0, 255));
      ys[PT_IDX_W'(i)] = PIX_W'($urandom_range(0, 255));
    end
    mode = $urandom_range(0, 9);
    if (mode < 9) begin
      for (i = 0; i < MAX_POINTS-1; i++) begin
        for (j = 0; j < MAX_POINTS-1-i; j++) begin
          if (xs[PT_IDX_W'(j)] > xs[PT_IDX_W'(j+1)]) begin
            t                  = xs[PT_IDX_W'(j)];
            xs[PT_IDX_W'(j)]   = xs[PT_IDX_W'(j+1)];
            xs[PT_IDX_W'(j+1)] = t;
          end
        end
      end
    end
    if (mode >= 7) begin
      j                = $urandom_range(1, MAX_POINTS-1);
      xs[PT_IDX_W'(j)] = xs[PT_IDX_W'(j-1)];
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int g;
    g = burst_mode ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver: random stalls, ready bursts, and one long hold-off on request
  initial begin
    int g;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < 20) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 100)) @(posedge clk);
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    pt_vec_t          xs;
    pt_vec_t          ys;
    logic [PIX_W-1:0] reset_pix[12];
    int               sent;
    int               phase;
    int               n;
    int               i;
    reset_pix = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd191, 8'd192, 8'd193,
                  8'd254, 8'd255, 8'h55, 8'hAA};
    cur_in  = IN_PT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (reset_pix[i]) send_pixel(reset_pix[i]);
    in_valid <= 1'b0;

    // zero-width segments at 50, then 50..200
    load_curve({8'd200, 8'd50, 8'd50, 8'd50}, {8'd240, 8'd90, 8'd10, 8'd10});
    send_pixel(8'd49);
    send_pixel(8'd50);
    send_pixel(8'd51);
    send_pixel(8'd200);
    in_valid <= 1'b0;

    // full-range falling segment between zero-width ends
    load_curve({8'd255, 8'd255, 8'd0, 8'd0}, {8'd255, 8'd0, 8'd255, 8'd0});
    send_pixel(8'd0);
    send_pixel(8'd1);
    send_pixel(8'd128);
    send_pixel(8'd255);
    in_valid <= 1'b0;

    // decreasing breakpoints skipped, falling last segment
    load_curve({8'd255, 8'd50, 8'd100, 8'd200}, {8'd1, 8'd250, 8'd3, 8'd200});
    send_pixel(8'd40);
    send_pixel(8'd100);
    send_pixel(8'd150);
    send_pixel(8'd255);
    in_valid <= 1'b0;

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          xs = '0;
          ys = '1;
        end
        1: begin
          xs = '1;
          ys = '0;
        end
        default: random_curve(xs, ys);
      endcase
      load_curve(xs, ys);
      burst_mode = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 140);
      // long enough to outlast any receiver burst before the hold-off starts
      if (phase == 3) begin
        burst_mode = 1'b1;
        hold_req   = 1'b1;
        n          = 160;
      end
      for (i = 0; i < n; i++) send_pixel(pick_pixel());
      in_valid <= 1'b0;
      sent += n;
      phase++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
rtl/core/plpm_pkg.sv
rtl/core/plpm_cfg.sv
rtl/core/plpm_front.sv
rtl/core/plpm_div.sv
rtl/core/plpm_out.sv
rtl/core/piecewise_linear_pixel_map.sv
rtl/core/plpm_checker.sv
dv/plpm_checker.sv
dv/tb_piecewise_linear_pixel_map.sv
